// ===== src/kmsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsl_pkg
// Shared sizes and the per-row record of the keypad matrix scanner.
// ----------------------------------------------------------------------------
package kmsl_pkg;

   // matrix geometry
   localparam int ROWS  = 8;
   localparam int COLS  = 4;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   // fixed field widths
   localparam int COLBITS_W = 4;
   localparam int CNT_W     = 4;

   // lockout register reset value
   localparam logic [CNT_W-1:0] LOCKOUT_RESET = CNT_W'(4);

   // last row index, where the scan wraps
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   // one row of the matrix: stored levels and a lockout counter per column
   typedef struct packed {
      logic [COLS-1:0]            levels;
      logic [COLS-1:0][CNT_W-1:0] counts;
   } row_rec_type;

endpackage

// ===== src/kmsl_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsl_update
// Per-column lockout and change detection for the row at the head of the ring.
// ----------------------------------------------------------------------------
module kmsl_update (
   input  kmsl_pkg::row_rec_type         rec_in,
   input  logic [kmsl_pkg::COLS-1:0]     column_bits,
   input  logic [kmsl_pkg::CNT_W-1:0]    lockout_visits,
   output kmsl_pkg::row_rec_type         rec_out,
   output logic [kmsl_pkg::COLS-1:0]     changed
);

   // each column is independent of the others
   always_comb begin
      rec_out = rec_in;
      changed = '0;
      for (int c = 0; c < kmsl_pkg::COLS; c++) begin
         if (rec_in.counts[c] != '0) begin
            rec_out.counts[c] = rec_in.counts[c] - kmsl_pkg::CNT_W'(1);
         end else if (column_bits[c] != rec_in.levels[c]) begin
            rec_out.levels[c] = column_bits[c];
            rec_out.counts[c] = lockout_visits;
            changed[c]        = 1'b1;
         end
      end
   end

endmodule

// ===== src/kmsl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsl_cell
// One slot of the row ring: holds a row record and takes its neighbour's on
// every accepted beat.
// ----------------------------------------------------------------------------
module kmsl_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  kmsl_pkg::row_rec_type rec_in,
   output kmsl_pkg::row_rec_type rec_out
);

   kmsl_pkg::row_rec_type state_ff;
   kmsl_pkg::row_rec_type state_in;

   // hold unless the ring turns
   always_comb begin
      state_in = shift_en ? rec_in : state_ff;
   end

   // state register, cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rec_out = state_ff;

endmodule

// ===== src/key_matrix_scanner_lockout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_scanner_lockout
// Keypad matrix scanner with per-switch change lockout, one row per poll.
// ----------------------------------------------------------------------------
// Each request beat carries the column levels read for the row currently
// driven; one response beat comes back per request with the scanned row, the
// mask of switches that changed, the stored levels of that row and the row to
// drive next. Rows are kept in a ring of cells that turns by one slot on every
// accepted beat, so the head cell always holds the row being scanned and the
// per-column update is a single compare and counter step. A request is taken
// every cycle while the response register is empty or being drained, and the
// response shows in the cycle after acceptance. A switch that reports a change
// ignores its column for lockout_visits further visits; lockout_visits resets
// to 4 and may be written through the csr port while the block is idle.
// ----------------------------------------------------------------------------
module key_matrix_scanner_lockout (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [kmsl_pkg::COLBITS_W-1:0]  req_column_bits,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [kmsl_pkg::ROW_W-1:0]      rsp_scanned_row,
   output logic [kmsl_pkg::COLS-1:0]       rsp_changed_mask,
   output logic [kmsl_pkg::COLS-1:0]       rsp_row_levels,
   output logic [kmsl_pkg::ROW_W-1:0]      rsp_drive_row,
   // configuration
   input  logic                            csr_wr_en,
   input  logic [kmsl_pkg::CNT_W-1:0]      csr_wr_data
);

   logic                          accept;
   logic [kmsl_pkg::CNT_W-1:0]    lockout_ff;
   logic [kmsl_pkg::CNT_W-1:0]    lockout_in;
   logic [kmsl_pkg::ROW_W-1:0]    row_ff;
   logic [kmsl_pkg::ROW_W-1:0]    row_in;
   logic [kmsl_pkg::ROW_W-1:0]    next_row;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [kmsl_pkg::ROW_W-1:0]    scanned_ff;
   logic [kmsl_pkg::COLS-1:0]     changed_ff;
   logic [kmsl_pkg::COLS-1:0]     levels_ff;
   logic [kmsl_pkg::ROW_W-1:0]    drive_ff;
   logic [kmsl_pkg::COLS-1:0]     changed;
   kmsl_pkg::row_rec_type         head_upd;
   kmsl_pkg::row_rec_type         ring [kmsl_pkg::ROWS];

   // handshake: the response register parts the two sides
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // lockout register
   always_comb begin
      lockout_in = csr_wr_en ? csr_wr_data : lockout_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= kmsl_pkg::LOCKOUT_RESET;
      end else begin
         lockout_ff <= lockout_in;
      end
   end

   // row counter, wraps after the last row
   always_comb begin
      next_row = (row_ff == kmsl_pkg::LAST_ROW) ? '0 : row_ff + kmsl_pkg::ROW_W'(1);
      row_in   = accept ? next_row : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   // update of the head row
   kmsl_update u_update (
      .rec_in         (ring[0]),
      .column_bits    (req_column_bits[kmsl_pkg::COLS-1:0]),
      .lockout_visits (lockout_ff),
      .rec_out        (head_upd),
      .changed        (changed)
   );

   // ring of row cells, updated head goes to the tail
   for (genvar i = 0; i < kmsl_pkg::ROWS; i++) begin : g_cell
      if (i == kmsl_pkg::ROWS - 1) begin : g_tail
         kmsl_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (accept),
            .rec_in   (head_upd),
            .rec_out  (ring[i])
         );
      end else begin : g_body
         kmsl_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (accept),
            .rec_in   (ring[i+1]),
            .rec_out  (ring[i])
         );
      end
   end

   // response valid
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         scanned_ff <= row_ff;
         changed_ff <= changed;
         levels_ff  <= head_upd.levels;
         drive_ff   <= next_row;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scanned_row  = scanned_ff;
   assign rsp_changed_mask = changed_ff;
   assign rsp_row_levels   = levels_ff;
   assign rsp_drive_row    = drive_ff;

endmodule
